// ----- hw/rtl/frie_pkg.sv -----
// frie_pkg: shared constants and the rounding function for the round-to-integral block
// no dependencies
`default_nettype none
package frie_pkg;
  localparam int unsigned DataW = 64;
  localparam logic FmtDouble = 1'b0;
  localparam logic FmtSingle = 1'b1;

  // round one pattern, ebits exponent and mbits fraction bits in low bits
  function automatic logic [63:0] frie_round(input logic [63:0] bits, input logic single);
    logic [63:0] sign_bit, mag, exp, exp_max, bias, one, half_val, mask, half, rem, base;
    logic [63:0] fsh;
    logic [6:0] f;
    logic [6:0] mbits;
    logic odd;
    logic [63:0] res;
    mbits = single ? 7'd23 : 7'd52;
    sign_bit = single ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    mag = bits & (sign_bit - 64'd1);
    exp_max = single ? 64'd255 : 64'd2047;
    bias = single ? 64'd127 : 64'd1023;
    exp = mag >> mbits;
    one = bias << mbits;
    half_val = (bias - 64'd1) << mbits;
    f = 7'((bias + 64'(mbits)) - exp);
    fsh = 64'd1 << f[5:0];
    mask = fsh - 64'd1;
    half = fsh >> 1;
    rem = mag & mask;
    base = mag & ~mask;
    odd = (f == mbits) ? 1'b1 : |(base & fsh);
    if (exp == exp_max || mag == 64'd0 || exp >= bias + 64'(mbits)) begin
      res = bits;
    end else if (exp < bias - 64'd1) begin
      res = 64'd0;
    end else if (exp == bias - 64'd1) begin
      if (mag == half_val) res = 64'd0;
      else res = (bits & sign_bit) | one;
    end else if (rem == 64'd0) begin
      res = bits;
    end else begin
      if (rem > half || (rem == half && odd)) base = base + fsh;
      res = (bits & sign_bit) | base;
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/frie_datapath.sv -----
// frie_datapath: combinational rounding between the request and result registers
// depends on frie_pkg
`default_nettype none
module frie_datapath (
  input  wire logic                        single,
  input  wire logic [frie_pkg::DataW-1:0]  value_bits,
  output logic      [frie_pkg::DataW-1:0]  result_bits
);
  import frie_pkg::*;
  logic [DataW-1:0] op;
  assign op = (single == FmtSingle) ? {32'd0, value_bits[31:0]} : value_bits;
  assign result_bits = frie_round(op, single == FmtSingle);
endmodule
`default_nettype wire

// ----- hw/rtl/fp_round_to_integral_even_core.sv -----
// fp_round_to_integral_even_core: top level, request register, rounding logic, result register
// depends on frie_pkg and frie_datapath
//
// channel | ports                              | handshake
// request | in_command, in_value_bits          | start, busy (busy tied low)
// result  | out_result_bits                    | out_valid strobe, one cycle
//
// start passes through the request register and then the result register to out_valid;
// one request accepted every cycle, with the rounding logic combinational between the two
// registers; synchronous active-low reset clears the valid flags only
// the receiver cannot stall, so busy is always low
`default_nettype none
module fp_round_to_integral_even_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_command,
  input  wire logic [frie_pkg::DataW-1:0]  in_value_bits,
  output logic                             out_valid,
  output logic      [frie_pkg::DataW-1:0]  out_result_bits
);
  import frie_pkg::*;
  // request register
  logic             req_vld_r;
  logic             cmd_r;
  logic [DataW-1:0] val_r;
  logic [DataW-1:0] res_nxt;
  logic [DataW-1:0] res_r;
  logic             out_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start;
      out_vld_r <= req_vld_r;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= in_command;
      val_r <= in_value_bits;
    end
    res_r <= res_nxt;
  end

  frie_datapath u_dp (
    .single     (cmd_r),
    .value_bits (val_r),
    .result_bits(res_nxt)
  );

  assign out_valid       = out_vld_r;
  assign out_result_bits = res_r;
endmodule
`default_nettype wire

// ----- hw/rtl/frie_checker.sv -----
// frie_checker: port-level assertions for the round-to-integral core
// depends on fp_round_to_integral_even_core ports
`default_nettype none
module frie_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_command,
  input wire logic [63:0] in_value_bits,
  input wire logic        out_valid,
  input wire logic [63:0] out_result_bits
);
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid) else $error("result missing");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(start) |=> !out_valid) else $error("spurious result");
  a_single_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_command) |-> ##2 (out_result_bits[63:32] == 32'd0))
    else $error("single upper bits set");
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !in_command && in_value_bits[62:52] == 11'h7ff) |-> ##2
    (out_result_bits == $past(in_value_bits, 2))) else $error("nan/inf changed");
endmodule
bind fp_round_to_integral_even_core frie_checker u_chk (.*);
`default_nettype wire

// ----- tb/tb_fp_round_to_integral_even_core.sv -----
// testbench for fp_round_to_integral_even_core: directed and random requests, results checked
// against an in-bench bit-level rounding predictor; depends on frie_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_fp_round_to_integral_even_core;
  import frie_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 8;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [DataW-1:0] in_value_bits;
  logic out_valid;
  logic [DataW-1:0] out_result_bits;

  // expected rounded patterns, oldest first
  logic [63:0] rounded_q[$];
  int fail_count;
  int idle_cycles;

  fp_round_to_integral_even_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_value_bits(in_value_bits),
    .out_valid(out_valid),
    .out_result_bits(out_result_bits)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // round one pattern with ebits exponent and mbits fraction bits, ties to even
  function automatic logic [63:0] round_even(input logic [63:0] bits, input int ebits,
                                             input int mbits);
    logic [63:0] sgn, mag, emax, bias, ex, one_pat, half_pat, mask, half, rem, base;
    int f;
    bit odd;
    sgn = 64'd1 << (ebits + mbits);
    mag = bits & (sgn - 64'd1);
    emax = (64'd1 << ebits) - 64'd1;
    bias = (64'd1 << (ebits - 1)) - 64'd1;
    ex = mag >> mbits;
    one_pat = bias << mbits;
    half_pat = (bias - 64'd1) << mbits;
    // nan, infinity, signed zero and large values pass through
    if (ex == emax || mag == 64'd0 || ex >= bias + mbits) return bits;
    // below one half always gives +0
    if (ex < bias - 64'd1) return 64'd0;
    if (ex == bias - 64'd1) begin
      // exact half ties to zero, and zero is positive here
      if (mag == half_pat) return 64'd0;
      return (bits & sgn) | one_pat;
    end
    f = int'(bias + mbits - ex);
    mask = (64'd1 << f) - 64'd1;
    half = 64'd1 << (f - 1);
    rem = mag & mask;
    if (rem == 64'd0) return bits;
    base = mag & ~mask;
    // with every fraction bit below the point the integer part is the hidden 1
    odd = (f == mbits) ? 1'b1 : base[f];
    if (rem > half || (rem == half && odd)) base = base + (64'd1 << f);
    return (bits & sgn) | base;
  endfunction

  function automatic logic [63:0] predict_rounded(input logic cmd, input logic [63:0] v);
    if (cmd == FmtSingle) return round_even({32'd0, v[31:0]}, 8, 23) & 64'hFFFF_FFFF;
    return round_even(v, 11, 52);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // send one request after a random gap, record its expected result
  task automatic send_request(input logic cmd, input logic [63:0] v);
    int gap;
    gap = $urandom_range(0, 11);
    // about a third of requests go back to back
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_value_bits <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    rounded_q.push_back(predict_rounded(cmd, v));
    @(negedge clk);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    in_command <= 1'($urandom_range(0, 1));
    in_value_bits <= {$urandom, $urandom};
  endtask

  // result checker, one strobe per result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rounded_q.size() == 0) begin
        report_mismatch("unexpected result", out_result_bits, 64'd0);
      end else begin
        logic [63:0] want;
        want = rounded_q.pop_front();
        if (out_result_bits !== want) report_mismatch("result_bits", out_result_bits, want);
      end
    end
  end

  // watchdog counts cycles with nothing accepted and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired at %0t", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // special values in both formats: zeros, infinities, nans, halves, ties
  task automatic test_directed();
    logic [63:0] dbl[$];
    logic [31:0] sgl[$];
    dbl = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
            64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001,
            64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
            64'h4004_0000_0000_0000, 64'hBFEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
            64'h4330_0000_0000_0000, 64'h432F_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    sgl = '{32'h3F00_0000, 32'hBF00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'h7FC0_0001,
            32'hFF80_0000, 32'h8000_0000, 32'h80000001, 32'h4B00_0000, 32'h4AFF_FFFF};
    foreach (dbl[i]) send_request(FmtDouble, dbl[i]);
    // upper half filled with noise to show it is ignored
    foreach (sgl[i]) send_request(FmtSingle, {$urandom, sgl[i]});
    end_burst();
  endtask

  // random operands, exponents mostly near the rounding range
  task automatic test_random(input int count);
    logic cmd;
    logic [63:0] v;
    int k;
    for (k = 0; k < count; k++) begin
      cmd = 1'($urandom_range(0, 1));
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: ;  // fully random pattern
        1: begin
          if (cmd == FmtDouble) v[62:52] = 11'd1021 + 11'($urandom_range(0, 55));
          else v[30:23] = 8'd125 + 8'($urandom_range(0, 26));
        end
        2: begin
          // exact halves and near ties
          if (cmd == FmtDouble) begin
            v[62:52] = 11'd1023 + 11'($urandom_range(0, 52));
            v[51:0] = (52'd1 << $urandom_range(0, 51)) + 52'($signed($urandom_range(0, 2)) - 1);
          end else begin
            v[30:23] = 8'd127 + 8'($urandom_range(0, 23));
            v[22:0] = (23'd1 << $urandom_range(0, 22)) + 23'($signed($urandom_range(0, 2)) - 1);
          end
        end
        default: begin
          if (cmd == FmtDouble) v[62:52] = 11'($urandom_range(1000, 1080));
          else v[30:23] = 8'($urandom_range(100, 155));
        end
      endcase
      send_request(cmd, v);
      // occasional pause to let the pipeline drain
      if ($urandom_range(0, 15) == 0) begin
        end_burst();
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
    end_burst();
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = 1'b0;
    in_value_bits = '0;
    fail_count = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(925);

    waited = 0;
    while (rounded_q.size() != 0 && waited < WatchdogLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && rounded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
